// ----- rtl/gmr_pkg.sv -----
// Shared types, constants and helper functions of the GF(2^m) multiply and power block.
`default_nettype none

package gmr_pkg;

  // Field and word widths.
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned EXP_W          = 16;
  localparam int unsigned DEG_W          = 7;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned EBIT_W         = 4;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned MAX_DEGREE_DEF = 64;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DEGREE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCTION_TERMS = CFG_IDX_W'(1);

  // Register reset values: f(x) = x^8 + x^4 + x^3 + x + 1.
  localparam logic [DEG_W-1:0]  FIELD_DEGREE_RST    = DEG_W'(8);
  localparam logic [DATA_W-1:0] REDUCTION_TERMS_RST = DATA_W'(27);

  // Command codes.
  localparam logic CMD_MULTIPLY = 1'b0;
  localparam logic CMD_POWER    = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_START_RED,
    DP_START_MUL_AB,
    DP_START_SQR,
    DP_START_MUL_BASE,
    DP_STEP,
    DP_BASE_RAW,
    DP_BASE_ACC,
    DP_OUT_ACC,
    DP_OUT_RAW
  } dp_op_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RED,
    S_BASE,
    S_NEXT,
    S_MUL,
    S_AFTER,
    S_EMIT
  } ctrl_state_e;

  // Command from controller to datapath.
  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic             a_high;
    logic             b_high;
    logic [IDX_W-1:0] m_last;
  } dp_status_t;

  // Mask of the coefficients below x^m.
  function automatic logic [DATA_W-1:0] low_mask(input logic [DEG_W-1:0] m);
    if (m >= DEG_W'(DATA_W)) begin
      return '1;
    end
    return (DATA_W'(1) << m) - DATA_W'(1);
  endfunction

  // Index of the highest set bit of the exponent, zero for a zero exponent.
  function automatic logic [EBIT_W-1:0] exp_top_bit(input logic [EXP_W-1:0] e);
    logic [EBIT_W-1:0] t;
    t = '0;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) begin
        t = EBIT_W'(i);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gmr_if.sv -----
// Valid/ready channel interfaces for input words, result words and configuration writes.
`default_nettype none

interface gmr_in_if;
  import gmr_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [DATA_W-1:0] operand_a;
  logic [DATA_W-1:0] operand_b;
  logic [EXP_W-1:0]  exponent;

  modport source (output valid, command, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, command, operand_a, operand_b, exponent, output ready);
endinterface

interface gmr_out_if;
  import gmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

interface gmr_cfg_if;
  import gmr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/gmr_datapath.sv -----
// Bit-serial multiply-and-reduce datapath with operand, base, accumulator and result registers.
`default_nettype none

module gmr_datapath #(
  parameter int unsigned MAX_DEGREE = gmr_pkg::MAX_DEGREE_DEF
) (
  input  wire                          clk_i,
  input  wire gmr_pkg::dp_cmd_t        dp_cmd_i,
  input  wire [gmr_pkg::DATA_W-1:0]    operand_a_i,
  input  wire [gmr_pkg::DATA_W-1:0]    operand_b_i,
  input  wire [gmr_pkg::DEG_W-1:0]     field_degree_i,
  input  wire [gmr_pkg::DATA_W-1:0]    reduction_terms_i,
  output gmr_pkg::dp_status_t          dp_status_o,
  output logic [gmr_pkg::DATA_W-1:0]   result_o
);
  import gmr_pkg::*;

  localparam logic [DEG_W-1:0] MaxDeg = DEG_W'(MAX_DEGREE);
  localparam logic [DEG_W-1:0] MinDeg = DEG_W'(2);

  logic [DEG_W-1:0]  m_eff;
  logic [IDX_W-1:0]  m_last;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] r_eff;
  logic [DATA_W-1:0] step_val;

  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] base_q, base_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] mulr_q, mulr_d;
  logic [DATA_W-1:0] mcand_q, mcand_d;
  logic [DATA_W-1:0] res_q, res_d;

  // Effective degree, clamped to the supported range, and the field masks.
  always_comb begin
    if (field_degree_i < MinDeg) begin
      m_eff = MinDeg;
    end else if (field_degree_i > MaxDeg) begin
      m_eff = MaxDeg;
    end else begin
      m_eff = field_degree_i;
    end
  end

  assign m_last = IDX_W'(m_eff - DEG_W'(1));
  assign mask   = low_mask(m_eff);
  assign r_eff  = reduction_terms_i & mask;

  // One Horner step: multiply the accumulator by x modulo f, then add the
  // multiplicand when the selected multiplier coefficient is set.
  always_comb begin
    step_val = (acc_q << 1) & mask;
    if (acc_q[m_last]) begin
      step_val = step_val ^ r_eff;
    end
    if (mulr_q[dp_cmd_i.idx]) begin
      step_val = step_val ^ mcand_q;
    end
  end

  // Register updates per controller operation.
  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    base_d  = base_q;
    acc_d   = acc_q;
    mulr_d  = mulr_q;
    mcand_d = mcand_q;
    res_d   = res_q;
    unique case (dp_cmd_i.op)
      DP_NOP: begin
      end
      DP_LOAD: begin
        a_d = operand_a_i;
        b_d = operand_b_i;
      end
      DP_START_RED: begin
        mulr_d  = a_q;
        mcand_d = DATA_W'(1);
        acc_d   = '0;
      end
      DP_START_MUL_AB: begin
        mulr_d  = b_q;
        mcand_d = base_q;
        acc_d   = '0;
      end
      DP_START_SQR: begin
        mulr_d  = acc_q;
        mcand_d = acc_q;
        acc_d   = '0;
      end
      DP_START_MUL_BASE: begin
        mulr_d  = acc_q;
        mcand_d = base_q;
        acc_d   = '0;
      end
      DP_STEP: begin
        acc_d = step_val;
      end
      DP_BASE_RAW: begin
        base_d = a_q;
        acc_d  = a_q;
      end
      DP_BASE_ACC: begin
        base_d = acc_q;
      end
      DP_OUT_ACC: begin
        res_d = acc_q;
      end
      DP_OUT_RAW: begin
        res_d = a_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    base_q  <= base_d;
    acc_q   <= acc_d;
    mulr_q  <= mulr_d;
    mcand_q <= mcand_d;
    res_q   <= res_d;
  end

  // Status toward the controller.
  assign dp_status_o.a_high = |(a_q & ~mask);
  assign dp_status_o.b_high = |(b_q & ~mask);
  assign dp_status_o.m_last = m_last;
  assign result_o           = res_q;

endmodule

`default_nettype wire

// ----- rtl/gmr_ctrl.sv -----
// Sequencing state machine for reduction, multiply and square-and-multiply power.
`default_nettype none

module gmr_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          in_command_i,
  input  wire [gmr_pkg::EXP_W-1:0]     in_exponent_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  input  wire gmr_pkg::dp_status_t     dp_status_i,
  output gmr_pkg::dp_cmd_t             dp_cmd_o
);
  import gmr_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic              cmd_q, cmd_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  logic [EBIT_W-1:0] ebit_q, ebit_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              sqr_q, sqr_d;
  logic              out_valid_q, out_valid_d;
  logic              raw_result;
  logic              slot_free;

  // Exponents of zero or one hand back operand a as given.
  assign raw_result = (cmd_q == CMD_POWER) && (exp_q[EXP_W-1:1] == '0);
  assign slot_free  = !out_valid_q || out_ready_i;

  // State register and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_MULTIPLY;
      ebit_q      <= '0;
      cnt_q       <= '0;
      sqr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      ebit_q      <= ebit_d;
      cnt_q       <= cnt_d;
      sqr_q       <= sqr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Exponent is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
  end

  // Next state and datapath commands.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    exp_d        = exp_q;
    ebit_d       = ebit_q;
    cnt_d        = cnt_q;
    sqr_d        = sqr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    dp_cmd_o.op  = DP_NOP;
    dp_cmd_o.idx = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.op = DP_LOAD;
          cmd_d       = in_command_i;
          exp_d       = in_exponent_i;
          state_d     = S_SETUP;
        end
      end
      S_SETUP: begin
        ebit_d = exp_top_bit(exp_q);
        if (raw_result) begin
          state_d = S_EMIT;
        end else if (dp_status_i.a_high) begin
          dp_cmd_o.op = DP_START_RED;
          cnt_d       = '1;
          state_d     = S_RED;
        end else begin
          dp_cmd_o.op = DP_BASE_RAW;
          state_d     = S_NEXT;
        end
      end
      S_RED: begin
        dp_cmd_o.op = DP_STEP;
        if (cnt_q == '0) begin
          state_d = S_BASE;
        end else begin
          cnt_d = cnt_q - IDX_W'(1);
        end
      end
      S_BASE: begin
        dp_cmd_o.op = DP_BASE_ACC;
        state_d     = S_NEXT;
      end
      S_NEXT: begin
        if (cmd_q == CMD_MULTIPLY) begin
          // An unreduced b needs all of its coefficients walked.
          dp_cmd_o.op = DP_START_MUL_AB;
          cnt_d       = dp_status_i.b_high ? '1 : dp_status_i.m_last;
          sqr_d       = 1'b0;
          state_d     = S_MUL;
        end else if (ebit_q == '0) begin
          state_d = S_EMIT;
        end else begin
          dp_cmd_o.op = DP_START_SQR;
          ebit_d      = ebit_q - EBIT_W'(1);
          cnt_d       = dp_status_i.m_last;
          sqr_d       = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        dp_cmd_o.op = DP_STEP;
        if (cnt_q == '0) begin
          state_d = S_AFTER;
        end else begin
          cnt_d = cnt_q - IDX_W'(1);
        end
      end
      S_AFTER: begin
        if (cmd_q == CMD_MULTIPLY) begin
          state_d = S_EMIT;
        end else if (sqr_q && exp_q[ebit_q]) begin
          dp_cmd_o.op = DP_START_MUL_BASE;
          cnt_d       = dp_status_i.m_last;
          sqr_d       = 1'b0;
          state_d     = S_MUL;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          dp_cmd_o.op = raw_result ? DP_OUT_RAW : DP_OUT_ACC;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // A finished word lands in the output register on the next edge.
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && slot_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished word not presented");

  // A waiting word is never overwritten.
  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !out_ready_i) |=> (state_q == S_EMIT))
    else $error("result overwritten while waiting");

  // Each square consumes exactly one exponent bit.
  a_ebit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEXT && cmd_q == CMD_POWER && ebit_q != '0)
      |=> (ebit_q == $past(ebit_q) - EBIT_W'(1) && state_q == S_MUL && sqr_q))
    else $error("exponent bit index out of step");

  // The step counter runs out before the multiply state is left.
  a_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && cnt_q != '0) |=> (state_q == S_MUL))
    else $error("multiply left before last coefficient");

endmodule

`default_nettype wire

// ----- rtl/gf2m_multiply_reduce_power.sv -----
// Top level of the GF(2^m) polynomial-basis multiply and power block.
// A multiply walks b below x^m, or all of b when b has terms at or above x^m. A power
// squares once per exponent bit below the top set bit, multiplies by the base per further
// set bit, and passes a through for exponents of 0 or 1. An a with terms at or above x^m
// is reduced first otherwise. One word at a time, one coefficient per cycle; the next word
// is taken the cycle after a result is loaded, even while it waits. Reset: m = 8, r = 0x1B.
`default_nettype none

module gf2m_multiply_reduce_power #(
  parameter int unsigned MAX_DEGREE = gmr_pkg::MAX_DEGREE_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  gmr_in_if.sink     in_i,
  gmr_out_if.source  out_o,
  gmr_cfg_if.sink    cfg_i
);
  import gmr_pkg::*;

  logic [DEG_W-1:0]  field_degree_q;
  logic [DATA_W-1:0] reduction_terms_q;
  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_degree_q    <= FIELD_DEGREE_RST;
      reduction_terms_q <= REDUCTION_TERMS_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_FIELD_DEGREE) begin
        field_degree_q <= cfg_i.data[DEG_W-1:0];
      end else if (cfg_i.index == CFG_REDUCTION_TERMS) begin
        reduction_terms_q <= cfg_i.data;
      end
    end
  end

  // Sequencer.
  gmr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_command_i  (in_i.command),
    .in_exponent_i (in_i.exponent),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .dp_status_i   (dp_status),
    .dp_cmd_o      (dp_cmd)
  );

  // Datapath.
  gmr_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk_i             (clk_i),
    .dp_cmd_i          (dp_cmd),
    .operand_a_i       (in_i.operand_a),
    .operand_b_i       (in_i.operand_b),
    .field_degree_i    (field_degree_q),
    .reduction_terms_i (reduction_terms_q),
    .dp_status_o       (dp_status),
    .result_o          (out_o.result)
  );

endmodule

`default_nettype wire

// ----- tb/tb_gf2m_multiply_reduce_power.sv -----
// Self-checking testbench of the GF(2^m) multiply and power block with its own field predictor.
`timescale 1ns / 1ps

module tb_gf2m_multiply_reduce_power;
  import gmr_pkg::*;

  // Run control.
  localparam int unsigned FIELD_MAX   = MAX_DEGREE_DEF;
  localparam int          LIMIT       = 20_000_000;
  localparam int          IDLE_PCT    = 27;
  localparam int          CALM_FROM   = 400;
  localparam int          CALM_TO     = 650;
  localparam int          HOLD_AT     = 150;
  localparam int          HOLD_CYCLES = 600;
  localparam int          SETTLE      = 200;

  // Index that selects no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(8'hFF);

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [EXP_W-1:0]  exponent;
  } gf_word_t;

  logic clk_i;
  logic rst_ni;

  gmr_in_if  in_if ();
  gmr_out_if out_if ();
  gmr_cfg_if cfg_if ();

  gf2m_multiply_reduce_power DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predictor copy of the two field registers.
  logic [DEG_W-1:0]  field_degree_q = FIELD_DEGREE_RST;
  logic [DATA_W-1:0] field_terms_q  = REDUCTION_TERMS_RST;

  gf_word_t          words_to_send[$];
  logic [DATA_W-1:0] expected_elements[$];
  gf_word_t          next_word;
  logic [DATA_W-1:0] want_element;
  int                words_sent   = 0;
  int                words_taken  = 0;
  int                results_seen = 0;
  int                mismatches   = 0;
  int                hold_left    = 0;
  bit                hold_done    = 1'b0;
  int                cycle_count  = 0;

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Degrees below 2 act as 2 and degrees beyond the maximum act as the maximum.
  function automatic int active_degree(logic [DEG_W-1:0] d);
    if (d < 2) begin
      return 2;
    end
    if (d > FIELD_MAX) begin
      return FIELD_MAX;
    end
    return int'(d);
  endfunction

  function automatic logic [DATA_W-1:0] field_mask(int m);
    if (m >= DATA_W) begin
      return '1;
    end
    return (DATA_W'(1) << m) - DATA_W'(1);
  endfunction

  // Clears every coefficient at or above x^m by folding it back through r.
  function automatic logic [DATA_W-1:0] fold_into_field(logic [DATA_W-1:0] v, int m,
                                                        logic [DATA_W-1:0] r);
    for (int i = DATA_W - 1; i >= m; i--) begin
      if (v[i]) begin
        v[i] = 1'b0;
        v    = v ^ (r << (i - m));
      end
    end
    return v;
  endfunction

  // Bit-serial product, most significant bit of b first, reduced as it goes.
  function automatic logic [DATA_W-1:0] field_product(logic [DATA_W-1:0] a,
                                                      logic [DATA_W-1:0] b, int m,
                                                      logic [DATA_W-1:0] r);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] mask;
    logic              top;
    acc  = '0;
    mask = field_mask(m);
    for (int i = m - 1; i >= 0; i--) begin
      top = acc[m-1];
      acc = (acc << 1) & mask;
      if (top) begin
        acc = acc ^ r;
      end
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  // Field element that one input word must produce under the current registers.
  function automatic logic [DATA_W-1:0] predict_element(gf_word_t w);
    int                m;
    int                top;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] acc;
    m = active_degree(field_degree_q);
    r = field_terms_q & field_mask(m);
    if (w.command == CMD_MULTIPLY) begin
      return field_product(fold_into_field(w.operand_a, m, r),
                           fold_into_field(w.operand_b, m, r), m, r);
    end
    // An exponent of zero or one passes operand a through untouched.
    if (w.exponent <= 1) begin
      return w.operand_a;
    end
    base = fold_into_field(w.operand_a, m, r);
    acc  = base;
    top  = EXP_W - 1;
    while (top > 0 && !w.exponent[top]) begin
      top--;
    end
    for (int i = top - 1; i >= 0; i--) begin
      acc = field_product(acc, acc, m, r);
      if (w.exponent[i]) begin
        acc = field_product(acc, base, m, r);
      end
    end
    return acc;
  endfunction

  // Random idling, switched off inside the calm window.
  function automatic bit take_a_break(int count);
    if (count >= CALM_FROM && count < CALM_TO) begin
      return 1'b0;
    end
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  // Input driver: holds a word until it is taken, then offers the next one or idles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (words_sent == words_taken) begin
      if (words_to_send.size() != 0 && !take_a_break(words_taken)) begin
        next_word           = words_to_send.pop_front();
        in_if.valid        <= 1'b1;
        in_if.command      <= next_word.command;
        in_if.operand_a    <= next_word.operand_a;
        in_if.operand_b    <= next_word.operand_b;
        in_if.exponent     <= next_word.exponent;
        words_sent         <= words_sent + 1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Every accepted input word queues the element it must produce.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_elements.push_back(predict_element({in_if.command, in_if.operand_a,
                                                   in_if.operand_b, in_if.exponent}));
      words_taken <= words_taken + 1;
    end
  end

  // Long receiver hold-off once, so that the block backs up and stalls its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_done && words_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver readiness.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && !take_a_break(results_seen);
    end
  end

  // Result monitor: each accepted word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen <= results_seen + 1;
      if (expected_elements.size() == 0) begin
        $error("result: unexpected word, actual %h", out_if.result);
        mismatches++;
      end else begin
        want_element = expected_elements.pop_front();
        if (out_if.result !== want_element) begin
          $error("result: expected %h, actual %h", want_element, out_if.result);
          mismatches++;
        end
      end
    end
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_gf2m_multiply_reduce_power: FAIL");
      $finish;
    end
  end

  // Writes one register; only called while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    if (index == CFG_FIELD_DEGREE) begin
      field_degree_q = data[DEG_W-1:0];
    end else if (index == CFG_REDUCTION_TERMS) begin
      field_terms_q = data;
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_word(logic command, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                           logic [EXP_W-1:0] e);
    words_to_send.push_back({command, a, b, e});
  endtask

  // Random words, mostly reduced operands and mostly short exponents.
  task automatic push_random_words(int count);
    int                m;
    int                pick;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [EXP_W-1:0]  e;
    m = active_degree(field_degree_q);
    for (int n = 0; n < count; n++) begin
      a = rand64();
      b = rand64();
      if ($urandom_range(99) < 80) begin
        a = a & field_mask(m);
      end
      if ($urandom_range(99) < 80) begin
        b = b & field_mask(m);
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        e = EXP_W'($urandom_range(3));
      end else if (pick < 75) begin
        e = EXP_W'($urandom_range(255));
      end else begin
        e = EXP_W'($urandom_range(65535));
      end
      push_word($urandom_range(1) ? CMD_POWER : CMD_MULTIPLY, a, b, e);
    end
  endtask

  // Waits until every word has been taken and every result has come back.
  task automatic wait_for_drain();
    do begin
      @(posedge clk_i);
    end while (words_to_send.size() != 0 || words_sent != words_taken ||
               expected_elements.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // One field setting: registers, extreme operands for that field, then random words.
  task automatic run_phase(logic [DEG_W-1:0] degree, logic [DATA_W-1:0] terms, int count);
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] mask;
    data              = rand64();
    data[DEG_W-1:0]   = degree;
    write_reg(CFG_FIELD_DEGREE, data);
    write_reg(CFG_REDUCTION_TERMS, terms);
    mask = field_mask(active_degree(field_degree_q));
    push_word(CMD_MULTIPLY, mask, mask, '0);
    push_word(CMD_POWER, mask, rand64(), '1);
    push_word(CMD_MULTIPLY, '1, '1, '0);
    push_random_words(count);
    wait_for_drain();
  endtask

  initial begin
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_FIELD_DEGREE;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words in the reset field x^8 + x^4 + x^3 + x + 1.
    push_word(CMD_MULTIPLY, 64'h0, 64'h57, '0);
    push_word(CMD_MULTIPLY, 64'h1, 64'h1, '0);
    push_word(CMD_MULTIPLY, 64'h53, 64'hCA, '0);
    push_word(CMD_MULTIPLY, 64'hFF, 64'hFF, '0);
    push_word(CMD_MULTIPLY, 64'h80, 64'h02, '0);
    push_word(CMD_MULTIPLY, '1, 64'h03, '0);
    push_word(CMD_MULTIPLY, 64'h03, '1, '0);
    push_word(CMD_MULTIPLY, '1, '1, '1);
    push_word(CMD_POWER, '1, '1, 16'd0);
    push_word(CMD_POWER, 64'h1234, 64'h0, 16'd1);
    push_word(CMD_POWER, 64'h03, 64'h0, 16'd2);
    push_word(CMD_POWER, 64'h03, 64'h0, 16'hFFFF);
    push_word(CMD_POWER, 64'h02, 64'h0, 16'h8000);
    push_word(CMD_POWER, 64'h0, 64'h0, 16'd5);
    push_word(CMD_POWER, '1, 64'h0, 16'd3);
    push_word(CMD_POWER, 64'h53, 64'h0, 16'd254);
    push_random_words(80);
    wait_for_drain();

    // A walk through field settings, the degree extremes and out-of-range degrees among them.
    run_phase(7'd2, 64'd3, 100);
    run_phase(7'd64, 64'h1B, 60);
    run_phase(7'd0, rand64(), 100);
    run_phase(7'd127, rand64(), 50);
    write_reg(CFG_SPARE_INDEX, rand64());
    run_phase(7'd16, rand64(), 110);
    run_phase(DEG_W'($urandom_range(16, 3)), rand64(), 110);
    run_phase(7'd33, rand64(), 70);
    run_phase(DEG_W'($urandom_range(20, 2)), 64'd0, 110);
    run_phase(DEG_W'($urandom_range(12, 2)), '1, 110);
    run_phase(7'd8, 64'd27, 100);

    repeat (SETTLE) @(posedge clk_i);
    if (expected_elements.size() != 0) begin
      $error("result: %0d expected words never arrived", expected_elements.size());
    end
    if (mismatches == 0 && expected_elements.size() == 0) begin
      $display("tb_gf2m_multiply_reduce_power: PASS");
    end else begin
      $display("tb_gf2m_multiply_reduce_power: FAIL");
    end
    $finish;
  end

endmodule
